// ----- hdl/stbs_pkg.sv -----
`timescale 1ns / 1ps

package stbs_pkg;

  // Default sizing of the key table
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BITS    = 64;

  // Fixed field widths on the ports
  localparam int COUNT_BITS     = 7;
  localparam int INDEX_BITS     = 6;
  localparam int KEY_FIELD_BITS = 64;
  localparam int POS_BITS       = 6;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_BITS = 72;
  localparam int M_TDATA_BITS = 8;

  // APB register map
  localparam int PADDR_BITS = 2;
  localparam int PDATA_BITS = 32;
  localparam logic [PADDR_BITS-1:0] ADDR_ENTRY_COUNT = 2'd0;

  // Operation codes carried in s_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

// ----- hdl/stbs_ram.sv -----
`timescale 1ns / 1ps

// Single-port synchronous RAM, registered read.
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/sorted_table_binary_search_unit.sv -----
`timescale 1ns / 1ps
// Load beat: written to the key RAM on acceptance; loads may follow back to back.
// Search beat: accepted in IDLE, then per probe a RAM read of the midpoint (PROBE) and
//   a compare (COMPARE), at most floor(log2(TABLE_DEPTH))+1 probes, then DONE loads the
//   output register; when entry_count is zero it goes straight to DONE with no probe.
// A new beat is taken once the result sits in the output register, even if not yet taken.
// rst (synchronous, active high) clears entry_count, the FSM and m_tvalid; the RAM is not cleared.
module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_BITS-1:0]   paddr,
  input  logic [PDATA_BITS-1:0]   pwdata,
  output logic [PDATA_BITS-1:0]   prdata,
  output logic                    pready,
  // Input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [S_TDATA_BITS-1:0] s_tdata,  // [5:0] entry_index, [69:6] key, [71:70] zero
  input  logic                    s_tuser,  // [0] operation
  // Result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [M_TDATA_BITS-1:0] m_tdata,  // [5:0] position, [7:6] zero
  output logic                    m_tuser   // [0] found
);

  // RAM address width and width of the range bounds (which reach TABLE_DEPTH)
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    COMPARE,
    DONE
  } state_t;

  state_t state;

  // Configuration
  logic [COUNT_BITS-1:0] entry_count;
  logic                  cfg_write;

  // Input beat fields
  logic [INDEX_BITS-1:0]     in_index;
  logic [KEY_FIELD_BITS-1:0] in_key;
  logic                      in_op;
  logic                      in_accept;

  // Search state
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [AW-1:0]       mid;
  logic [CW:0]         mid_sum;
  logic [AW-1:0]       mid_next;
  logic [CW-1:0]       lo_next;
  logic [CW-1:0]       hi_next;
  logic [CW-1:0]       count_cap;
  logic                res_found;
  logic [POS_BITS-1:0] res_pos;

  // Output register
  logic                m_found;
  logic [POS_BITS-1:0] m_pos;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [KEY_BITS-1:0] ram_rdata;

  // ---------------- APB ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write && paddr == ADDR_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENTRY_COUNT) begin
      prdata = PDATA_BITS'(entry_count);
    end
  end

  // ---------------- input beat ----------------
  assign in_index  = s_tdata[INDEX_BITS-1:0];
  assign in_key    = s_tdata[INDEX_BITS +: KEY_FIELD_BITS];
  assign in_op     = s_tuser;
  assign s_tready  = (state == IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Counts above the table depth are clipped to it
  always_comb begin
    if (32'(entry_count) > TABLE_DEPTH) begin
      count_cap = CW'(TABLE_DEPTH);
    end else begin
      count_cap = CW'(entry_count);
    end
  end

  // Midpoint of [lo, hi) taken as floor((lo + hi - 1) / 2); hi >= 1 whenever used
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
  assign mid_next = mid_sum[AW:1];

  // Range update from the probed key
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (ram_rdata > key_q) begin
      hi_next = CW'(mid);
    end else begin
      lo_next = CW'(mid) + CW'(1);
    end
  end

  // Loads write in IDLE only; probes read later, so no forwarding is needed
  assign ram_we   = in_accept && in_op == OP_LOAD && 32'(in_index) < TABLE_DEPTH;
  assign ram_addr = (state == IDLE) ? AW'(in_index) : mid_next;

  stbs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_key[KEY_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- search sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in DONE the output register is reloaded whenever the old beat leaves
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_accept && in_op == OP_SEARCH) begin
            key_q <= in_key[KEY_BITS-1:0];
            lo    <= '0;
            hi    <= count_cap;
            if (count_cap == '0) begin
              // empty range: not found straight away
              res_found <= 1'b0;
              res_pos   <= '0;
              state     <= DONE;
            end else begin
              state <= PROBE;
            end
          end
        end
        PROBE: begin
          // RAM read of the midpoint issued this cycle
          mid   <= mid_next;
          state <= COMPARE;
        end
        COMPARE: begin
          if (ram_rdata == key_q) begin
            res_found <= 1'b1;
            res_pos   <= POS_BITS'(mid);
            state     <= DONE;
          end else begin
            lo <= lo_next;
            hi <= hi_next;
            if (lo_next < hi_next) begin
              state <= PROBE;
            end else begin
              res_found <= 1'b0;
              res_pos   <= '0;
              state     <= DONE;
            end
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_found  <= res_found;
            m_pos    <= res_pos;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = M_TDATA_BITS'(m_pos);
  assign m_tuser = m_found;

  // ---------------- assertions ----------------
  a_probe_range_live: assert property (@(posedge clk) disable iff (rst)
    state == PROBE |-> lo < hi)
    else $error("probe issued on an empty range");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    state == COMPARE |-> (CW'(mid) >= lo) && (CW'(mid) < hi))
    else $error("midpoint outside live range");

  a_compare_after_probe: assert property (@(posedge clk) disable iff (rst)
    state == PROBE |=> state == COMPARE)
    else $error("compare did not follow probe");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss reported with non-zero position");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

// Binary search over a loaded key table. Beats go in over the slave stream, results are
// checked in order against a local search of a shadow copy of the table.
module tb_top;
  import stbs_pkg::*;

  localparam int DEPTH         = DEF_TABLE_DEPTH;
  localparam int SETTLE_CYCLES = 24;    // covers the longest search, plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake of any kind
  localparam int PHASES        = 12;
  localparam int PHASE_BEATS   = 130;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] position;
  } search_result_t;

  // How the key table gets refilled between sweeps
  typedef enum int {
    FILL_WIDE,   // full 64-bit random keys
    FILL_NAMES,  // left-aligned ASCII names, zero padded
    FILL_DENSE   // small keys, lots of duplicates
  } fill_style_t;

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [PADDR_BITS-1:0]   paddr    = '0;
  logic [PDATA_BITS-1:0]   pwdata   = '0;
  logic [PDATA_BITS-1:0]   prdata;
  logic                    pready;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata  = '0;  // [5:0] entry_index, [69:6] key, [71:70] zero
  logic                    s_tuser  = 1'b0; // [0] operation
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;  // [5:0] position, [7:6] zero
  logic                    m_tuser;  // [0] found

  sorted_table_binary_search_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's state, updated at the edge where a beat is taken
  logic [KEY_FIELD_BITS-1:0] shadow_keys [DEPTH];
  logic [COUNT_BITS-1:0]     shadow_count = '0;
  search_result_t            pending_results [$];

  int mismatches    = 0;
  int loads_sent    = 0;
  int searches_sent = 0;
  int hits_seen     = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;
  bit gaps_on       = 1'b1;

  function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
  endfunction

  // Same probe order as the hardware: midpoint of [lo, hi), stop on the first equal key.
  // Count above the depth is clamped; count zero gives an empty range.
  function automatic search_result_t lookup_key(logic [KEY_FIELD_BITS-1:0] key);
    int             lo;
    int             hi;
    int             mid;
    search_result_t res;
    lo  = 0;
    hi  = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    res = '0;
    while (!res.found && lo < hi) begin
      mid = (lo + hi - 1) >> 1;
      if (shadow_keys[mid] == key) begin
        res.found    = 1'b1;
        res.position = mid[POS_BITS-1:0];
      end else if (shadow_keys[mid] > key) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  // One beat on the input stream. Called at a falling edge, returns at a falling edge,
  // so tvalid stays high across back-to-back beats.
  task automatic send_beat(input logic op, input logic [INDEX_BITS-1:0] idx,
                           input logic [KEY_FIELD_BITS-1:0] key);
    while (gaps_on && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, key, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      shadow_keys[idx] = key;
      loads_sent++;
    end else begin
      pending_results.push_back(lookup_key(key));
      searches_sent++;
    end
    @(negedge clk);
  endtask

  // Drain: all results back, then let a load or search still in flight finish
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write of entry_count, then a read back. Only called with the block idle.
  task automatic write_entry_count(input int unsigned value);
    logic [PDATA_BITS-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENTRY_COUNT;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_count = value[COUNT_BITS-1:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != PDATA_BITS'(shadow_count))
      report_mismatch("entry_count readback", 64'(shadow_count), 64'(readback));
    settings_used++;
  endtask

  // Load all entries with ascending keys of the chosen flavour
  task automatic fill_table(input fill_style_t style);
    logic [KEY_FIELD_BITS-1:0] keys [DEPTH];
    logic [KEY_FIELD_BITS-1:0] tmp;
    int                        i;
    int                        j;
    int                        len;
    for (i = 0; i < DEPTH; i++) begin
      case (style)
        FILL_WIDE: begin
          keys[i] = {$urandom, $urandom};
        end
        FILL_NAMES: begin
          tmp = '0;
          len = $urandom_range(1, 8);
          for (j = 0; j < len; j++) tmp[63-8*j -: 8] = 8'($urandom_range(65, 122));
          keys[i] = tmp;
        end
        default: begin
          keys[i] = 64'($urandom_range(0, 40));
        end
      endcase
    end
    // insertion sort, ascending unsigned
    for (i = 1; i < DEPTH; i++) begin
      tmp = keys[i];
      j   = i - 1;
      while (j >= 0 && keys[j] > tmp) begin
        keys[j+1] = keys[j];
        j--;
      end
      keys[j+1] = tmp;
    end
    for (i = 0; i < DEPTH; i++) send_beat(OP_LOAD, i[INDEX_BITS-1:0], keys[i]);
  endtask

  // Mostly searches over the live range, hits and near misses, with a few loads mixed in
  task automatic run_mixed_beats(input int beats);
    int                        n;
    int                        pick;
    int                        idx;
    int                        live;
    logic [KEY_FIELD_BITS-1:0] key;
    live = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    for (n = 0; n < beats; n++) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(0, DEPTH - 1);
      if (pick < 8) begin
        // copying the left neighbour keeps a sorted table sorted; a random key breaks it
        key = (pick < 4) ? shadow_keys[(idx == 0) ? 0 : idx - 1] : {$urandom, $urandom};
        send_beat(OP_LOAD, idx[INDEX_BITS-1:0], key);
      end else begin
        if (live > 0) idx = $urandom_range(0, live - 1);
        if (pick < 60)      key = shadow_keys[idx];
        else if (pick < 70) key = shadow_keys[idx] + 64'd1;
        else if (pick < 80) key = shadow_keys[idx] - 64'd1;
        else if (pick < 90) key = {$urandom, $urandom};
        else                key = pick[0] ? '1 : '0;
        send_beat(OP_SEARCH, INDEX_BITS'($urandom), key);
      end
    end
  endtask

  // Count zero straight out of reset: nothing is read, every search misses at 0
  task automatic test_empty_table();
    send_beat(OP_SEARCH, '0, '0);
    send_beat(OP_SEARCH, '1, '1);
    send_beat(OP_SEARCH, 6'd21, {$urandom, $urandom});
  endtask

  // Eight sorted entries spanning the key range, hits at both ends and in between
  task automatic test_sorted_extremes();
    logic [KEY_FIELD_BITS-1:0] keys [8];
    int                        i;
    keys = '{64'h0, 64'h1, 64'h0000_0000_FFFF_FFFF, 64'h4142_4300_0000_0000,
             64'h4142_4400_0000_0000, 64'h8000_0000_0000_0000,
             64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
    for (i = 0; i < 8; i++) send_beat(OP_LOAD, i[INDEX_BITS-1:0], keys[i]);
    wait_quiet();
    write_entry_count(8);
    send_beat(OP_SEARCH, '0, 64'h0);
    send_beat(OP_SEARCH, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(OP_SEARCH, '1, 64'h4142_4400_0000_0000);
    send_beat(OP_SEARCH, '0, 64'h4142_4300_0000_0001);  // between two names
    send_beat(OP_SEARCH, '1, 64'h8000_0000_0000_0001);
  endtask

  // Duplicate keys report the first one probed; an unsorted entry sends the probe astray
  task automatic test_duplicates_unsorted();
    send_beat(OP_LOAD, 6'd2, 64'h4142_4300_0000_0000);
    send_beat(OP_SEARCH, '0, 64'h4142_4300_0000_0000);
    send_beat(OP_LOAD, 6'd5, 64'h0);
    send_beat(OP_SEARCH, '0, 64'h0);
    send_beat(OP_SEARCH, '0, 64'h8000_0000_0000_0000);
    send_beat(OP_SEARCH, '0, 64'h1);
  endtask

  // Sweeps over several table sizes, including the clamp above the depth
  task automatic test_random_sweeps();
    int unsigned counts [PHASES];
    int          ph;
    counts = '{64, 1, 127, 0, 2, 63, 65, 33, 0, 0, 64, 96};
    counts[8] = $urandom_range(3, 62);
    counts[9] = $urandom_range(3, 62);
    for (ph = 0; ph < PHASES; ph++) begin
      gaps_on = !(ph >= 4 && ph <= 6);  // one long stretch at full rate
      wait_quiet();
      write_entry_count(counts[ph]);
      if (ph % 3 == 0) fill_table(fill_style_t'((ph / 3) % 3));
      run_mixed_beats(PHASE_BEATS);
    end
    gaps_on = 1'b1;
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    m_tready <= gaps_on ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // In-order check of each result beat against the oldest prediction
  always @(posedge clk) begin : check_results
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, 64'({m_tuser, m_tdata}));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.found)
          report_mismatch("found", 64'(want.found), 64'(m_tuser));
        if (m_tdata[POS_BITS-1:0] !== want.position)
          report_mismatch("position", 64'(want.position), 64'(m_tdata[POS_BITS-1:0]));
        if (want.found) hits_seen++;
      end
    end
  end

  // Watchdog: ends the run if nothing moves on any port for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else if (!rst) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_results.size());
        $display("sorted_table_binary_search_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_table();
    test_sorted_extremes();
    test_duplicates_unsorted();
    test_random_sweeps();
    wait_quiet();
    $display("covered %0d loads and %0d searches (%0d hits) over %0d entry_count settings",
             loads_sent, searches_sent, hits_seen, settings_used);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("sorted_table_binary_search_unit regression: pass");
    end else begin
      $display("sorted_table_binary_search_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/sorted_table_binary_search_unit.sv
verif/tb_top.sv
